FILE: src/gibm_pkg.sv
// Shared types and codes of the greedy IoU box matcher.
`default_nettype none
package gibm_pkg;

	// Input operation codes
	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_LOAD   = 2'd1,
		OP_DETECT = 2'd2,
		OP_END    = 2'd3
	} op_t;

	// Result kinds
	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_TOTALS  = 1'b1;

	localparam int THR_W       = 17;
	localparam int IOU_FRAC    = 16;
	localparam int CAT_IN_W    = 6;
	localparam int SLOT_OUT_W  = 5;
	localparam int IMG_CNT_W   = 16;
	localparam int TOT_W       = 32;
	localparam logic [THR_W-1:0] THR_RESET = 17'd39322;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic clear_img;
		logic load;
		logic det_start;
		logic slot_rd;
		logic stage_a;
		logic stage_b;
		logic stage_c;
		logic stage_d;
		logic stage_e;
		logic next_slot;
		logic thr_mul;
		logic decide;
		logic tot_rd;
		logic tot_wr;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic count_zero;
		logic live;
		logic last_slot;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

FILE: src/greedy_iou_box_matcher.sv
// Top level of the greedy IoU box matcher.
//
// Input channel (in_valid/in_ready) takes one operation per transaction:
// start image, load truth box, detection box or end image. Output channel
// (out_valid/out_ready) returns one result for each detection (verdict) and
// for each end of image (updated category totals); start and load give none.
// The user must write the threshold register through cfg_we/cfg_wdata
// only while idle; the block itself does not enforce this.
//
// A detection reads each filled store slot in turn; a retired slot is
// skipped, a still valid one goes through the one shared IoU datapath
// (area, intersection, union, two cross products, compare); this scan
// sets the detection time. End of image reads then writes the totals memory.
// The block accepts one transaction at a time; the next one is taken as
// soon as the work is done, even while a result waits in the output
// register. If the receiver stalls, a finished result holds in the output
// register and the next result-producing transaction waits for it.
// Reset clears the image state, the totals (valid bit per category) and
// loads the threshold default of about 0.6; no clearing pass is needed.
`default_nettype none
module greedy_iou_box_matcher
	import gibm_pkg::*;
#(
	parameter int MAX_TRUTH  = 32,
	parameter int CATEGORIES = 64,
	parameter int COORD_BITS = 13
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [THR_W-1:0]      cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            operation,
	input  wire logic [CAT_IN_W-1:0]   category,
	input  wire logic [COORD_BITS-1:0] box_x,
	input  wire logic [COORD_BITS-1:0] box_y,
	input  wire logic [COORD_BITS-1:0] box_w,
	input  wire logic [COORD_BITS-1:0] box_h,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       kind,
	output logic                       matched,
	output logic [SLOT_OUT_W-1:0]      truth_slot,
	output logic [CAT_IN_W-1:0]        out_category,
	output logic [TOT_W-1:0]           tp_total,
	output logic [TOT_W-1:0]           fp_total,
	output logic [TOT_W-1:0]           fn_total,
	output logic                       store_overflow
);

	cmd_t cmd;
	sts_t sts;

	gibm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (operation),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gibm_dp #(
		.MAX_TRUTH  (MAX_TRUTH),
		.CATEGORIES (CATEGORIES),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_cat    (category),
		.in_x      (box_x),
		.in_y      (box_y),
		.in_w      (box_w),
		.in_h      (box_h),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.o_kind    (kind),
		.o_matched (matched),
		.o_slot    (truth_slot),
		.o_cat     (out_category),
		.o_tp      (tp_total),
		.o_fp      (fp_total),
		.o_fn      (fn_total),
		.o_ovf     (store_overflow)
	);

	// An accepted transaction always keeps the block busy the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted back to back");

	// A totals result never carries a match
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_TOTALS) |-> !matched && (truth_slot == '0))
		else $error("totals result carries a match");

	// A verdict carries no totals, and an unmatched one no slot
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_VERDICT) |->
			(tp_total == '0) && (out_category == '0) && (matched || truth_slot == '0))
		else $error("verdict carries totals or stray slot");

endmodule
`default_nettype wire

FILE: src/gibm_ctrl.sv
// Sequencer of the matcher: image commands, slot scan and totals update.
`default_nettype none
module gibm_ctrl
	import gibm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] in_op,
	output logic            in_ready,
	input  wire sts_t       sts,
	output cmd_t            cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_LOAD, ST_DSETUP, ST_RD, ST_A, ST_B, ST_C, ST_D,
		ST_E, ST_THR, ST_DFIN, ST_ERD, ST_EWR
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (op_t'(in_op))
						OP_START:  state_d = ST_CLEAR;
						OP_LOAD:   state_d = ST_LOAD;
						OP_DETECT: state_d = ST_DSETUP;
						default:   state_d = ST_ERD;
					endcase
				end
			end
			ST_CLEAR: begin
				cmd.clear_img = 1'b1;
				state_d = ST_IDLE;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d = ST_IDLE;
			end
			ST_DSETUP: begin
				cmd.det_start = 1'b1;
				state_d = sts.count_zero ? ST_THR : ST_RD;
			end
			ST_RD: begin
				cmd.slot_rd = 1'b1;
				state_d = ST_A;
			end
			ST_A: begin
				if (sts.live) begin
					cmd.stage_a = 1'b1;
					state_d = ST_B;
				end else if (sts.last_slot) begin
					state_d = ST_THR;
				end else begin
					cmd.next_slot = 1'b1;
					state_d = ST_RD;
				end
			end
			ST_B: begin
				cmd.stage_b = 1'b1;
				state_d = ST_C;
			end
			ST_C: begin
				cmd.stage_c = 1'b1;
				state_d = ST_D;
			end
			ST_D: begin
				cmd.stage_d = 1'b1;
				state_d = ST_E;
			end
			ST_E: begin
				cmd.stage_e = 1'b1;
				if (sts.last_slot) begin
					state_d = ST_THR;
				end else begin
					cmd.next_slot = 1'b1;
					state_d = ST_RD;
				end
			end
			ST_THR: begin
				cmd.thr_mul = 1'b1;
				state_d = ST_DFIN;
			end
			ST_DFIN: begin
				// hold until the output register is free
				if (sts.out_free) begin
					cmd.decide = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_ERD: begin
				cmd.tot_rd = 1'b1;
				state_d = ST_EWR;
			end
			ST_EWR: begin
				if (sts.out_free) begin
					cmd.tot_wr = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

FILE: src/gibm_dp.sv
// Datapath of the matcher: truth store, IoU stages, best tracking and totals.
`default_nettype none
module gibm_dp
	import gibm_pkg::*;
#(
	parameter int MAX_TRUTH  = 32,
	parameter int CATEGORIES = 64,
	parameter int COORD_BITS = 13
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output sts_t                       sts,
	input  wire logic                  cfg_we,
	input  wire logic [THR_W-1:0]      cfg_wdata,
	input  wire logic [CAT_IN_W-1:0]   in_cat,
	input  wire logic [COORD_BITS-1:0] in_x,
	input  wire logic [COORD_BITS-1:0] in_y,
	input  wire logic [COORD_BITS-1:0] in_w,
	input  wire logic [COORD_BITS-1:0] in_h,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       o_kind,
	output logic                       o_matched,
	output logic [SLOT_OUT_W-1:0]      o_slot,
	output logic [CAT_IN_W-1:0]        o_cat,
	output logic [TOT_W-1:0]           o_tp,
	output logic [TOT_W-1:0]           o_fp,
	output logic [TOT_W-1:0]           o_fn,
	output logic                       o_ovf
);

	localparam int C      = COORD_BITS;
	localparam int SLOT_W = (MAX_TRUTH > 1) ? $clog2(MAX_TRUTH) : 1;
	localparam int CNT_W  = $clog2(MAX_TRUTH + 1);
	localparam int CAT_W  = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;
	localparam int SX_W   = C + 3;
	localparam int N_W    = 2 * C + 2;
	localparam int D_W    = 2 * C + 1;
	localparam int U_W    = 2 * C + 3;
	localparam int P_W    = N_W + D_W;
	localparam int T_W    = D_W + THR_W;
	localparam int B_W    = 4 * C;
	localparam int CE_W   = 9;

	// Captured transaction
	logic [CAT_IN_W-1:0] cat_q;
	logic [C-1:0]        bx_q, by_q, bw_q, bh_q;
	logic [THR_W-1:0]    thr_q;

	// Image state
	logic [CNT_W-1:0]     count_q;
	logic [IMG_CNT_W-1:0] tp_q, det_q;
	logic                 ovf_q;

	// Truth store
	logic [B_W-1:0] truth_mem [MAX_TRUTH];
	logic           valid_mem [MAX_TRUTH];
	logic [B_W-1:0] rd_box_s1;
	logic           rd_vld_s1;

	// Scan state
	logic [SLOT_W-1:0] slot_q, best_q;
	logic              found_q;
	logic [N_W-1:0]    bnum_q;
	logic [D_W-1:0]    bden_q;
	logic [2*C-1:0]    ab_q;
	logic [T_W-1:0]    thr_prod_q;

	// Stage registers
	logic [C:0]     sx_s2, sy_s2;
	logic [2*C-1:0] aa_s2;
	logic [N_W-1:0] inter_s3;
	logic [2*C-1:0] aa_s3;
	logic [N_W-1:0] num_s4;
	logic [D_W-1:0] den_s4;
	logic [P_W-1:0] lhs_s5, rhs_s5;

	// Totals store
	logic [3*TOT_W-1:0] tot_mem [CATEGORIES];
	logic [CATEGORIES-1:0] tot_vld_q;
	logic [3*TOT_W-1:0] tot_rd_s1;
	logic               tot_rv_s1;

	logic out_valid_q;

	// Capture the transaction and the threshold
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cat_q <= in_cat;
			bx_q  <= in_x;
			by_q  <= in_y;
			bw_q  <= in_w;
			bh_q  <= in_h;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// Store-full check and retire decision
	logic store_full;
	logic hit;
	logic [N_W+IOU_FRAC-1:0] bnum_sh;
	assign store_full = (count_q >= CNT_W'(MAX_TRUTH));
	assign bnum_sh    = {bnum_q, {IOU_FRAC{1'b0}}};
	assign hit        = found_q && (bnum_sh >= thr_prod_q);

	// Write truth boxes and valid marks
	logic              v_we, v_data;
	logic [SLOT_W-1:0] v_addr;
	always_comb begin
		v_we   = 1'b0;
		v_data = 1'b0;
		v_addr = best_q;
		if (cmd.load && !store_full) begin
			v_we   = 1'b1;
			v_data = 1'b1;
			v_addr = count_q[SLOT_W-1:0];
		end else if (cmd.decide && hit) begin
			v_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && !store_full) begin
			truth_mem[count_q[SLOT_W-1:0]] <= {bx_q, by_q, bw_q, bh_q};
		end
		if (v_we) begin
			valid_mem[v_addr] <= v_data;
		end
		if (cmd.slot_rd) begin
			rd_box_s1 <= truth_mem[slot_q];
			rd_vld_s1 <= valid_mem[slot_q];
		end
	end

	// Image counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tp_q    <= '0;
			det_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.clear_img) begin
			count_q <= '0;
			tp_q    <= '0;
			det_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.load) begin
			if (store_full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + CNT_W'(1);
			end
		end else if (cmd.decide) begin
			if (hit && (tp_q != '1)) begin
				tp_q <= tp_q + IMG_CNT_W'(1);
			end
			if (det_q != '1) begin
				det_q <= det_q + IMG_CNT_W'(1);
			end
		end
	end

	// Stage A: overlap sides and stored box area
	logic [C-1:0] ax, ay, aw, ah;
	logic [C:0]   ae, be, af, bf, min_x, min_y;
	logic [C-1:0] max_x, max_y;
	logic [SX_W-1:0] sx_raw, sy_raw;
	assign {ax, ay, aw, ah} = rd_box_s1;
	assign ae    = {1'b0, ax} + {1'b0, aw};
	assign be    = {1'b0, bx_q} + {1'b0, bw_q};
	assign af    = {1'b0, ay} + {1'b0, ah};
	assign bf    = {1'b0, by_q} + {1'b0, bh_q};
	assign min_x = (ae < be) ? ae : be;
	assign min_y = (af < bf) ? af : bf;
	assign max_x = (ax > bx_q) ? ax : bx_q;
	assign max_y = (ay > by_q) ? ay : by_q;
	assign sx_raw = SX_W'(min_x) - SX_W'(max_x) + SX_W'(1);
	assign sy_raw = SX_W'(min_y) - SX_W'(max_y) + SX_W'(1);

	// Stage C: union and clamp to zero IoU when not positive
	logic [U_W-1:0] uni;
	logic           uni_pos;
	assign uni     = U_W'(aa_s3) + U_W'(ab_q) - U_W'(inter_s3);
	assign uni_pos = !uni[U_W-1] && (uni != '0);

	// Advance the scan stages
	always_ff @(posedge clk) begin
		if (cmd.stage_a) begin
			sx_s2 <= sx_raw[SX_W-1] ? '0 : sx_raw[C:0];
			sy_s2 <= sy_raw[SX_W-1] ? '0 : sy_raw[C:0];
			aa_s2 <= (2*C)'(aw * ah);
		end
		if (cmd.stage_b) begin
			inter_s3 <= N_W'(sx_s2 * sy_s2);
			aa_s3    <= aa_s2;
		end
		if (cmd.stage_c) begin
			num_s4 <= uni_pos ? inter_s3 : '0;
			den_s4 <= uni_pos ? uni[D_W-1:0] : D_W'(1);
		end
		if (cmd.stage_d) begin
			lhs_s5 <= P_W'(num_s4 * bden_q);
			rhs_s5 <= P_W'(bnum_q * den_s4);
		end
		if (cmd.thr_mul) begin
			thr_prod_q <= T_W'(thr_q * bden_q);
		end
	end

	// Track the best candidate of the detection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			best_q  <= '0;
			found_q <= 1'b0;
			bnum_q  <= '0;
			bden_q  <= D_W'(1);
			ab_q    <= '0;
		end else if (cmd.det_start) begin
			slot_q  <= '0;
			best_q  <= '0;
			found_q <= 1'b0;
			bnum_q  <= '0;
			bden_q  <= D_W'(1);
			ab_q    <= (2*C)'(bw_q * bh_q);
		end else begin
			if (cmd.stage_e) begin
				if (!found_q) begin
					found_q <= 1'b1;
					best_q  <= slot_q;
				end
				if (lhs_s5 > rhs_s5) begin
					best_q <= slot_q;
					bnum_q <= num_s4;
					bden_q <= den_s4;
				end
			end
			if (cmd.next_slot) begin
				slot_q <= slot_q + SLOT_W'(1);
			end
		end
	end

	// Totals: category range and read-modify-write
	logic [CE_W-1:0]  cat_ext;
	logic [CAT_W-1:0] cat_idx;
	logic             cat_ok;
	logic [TOT_W-1:0] old_tp, old_fp, old_fn, new_tp, new_fp, new_fn;
	logic [TOT_W:0]   sum_tp, sum_fp, sum_fn;
	logic [CNT_W-1:0] left;
	logic [IMG_CNT_W-1:0] img_fp;
	assign cat_ext = CE_W'(cat_q);
	assign cat_idx = cat_ext[CAT_W-1:0];
	assign cat_ok  = (cat_ext < CE_W'(CATEGORIES));
	assign {old_tp, old_fp, old_fn} = tot_rv_s1 ? tot_rd_s1 : '0;
	assign left    = count_q - tp_q[CNT_W-1:0];
	assign img_fp  = det_q - tp_q;
	assign sum_tp  = {1'b0, old_tp} + (TOT_W+1)'(tp_q);
	assign sum_fp  = {1'b0, old_fp} + (TOT_W+1)'(img_fp);
	assign sum_fn  = {1'b0, old_fn} + (TOT_W+1)'(left);
	assign new_tp  = sum_tp[TOT_W] ? '1 : sum_tp[TOT_W-1:0];
	assign new_fp  = sum_fp[TOT_W] ? '1 : sum_fp[TOT_W-1:0];
	assign new_fn  = sum_fn[TOT_W] ? '1 : sum_fn[TOT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.tot_rd) begin
			tot_rd_s1 <= tot_mem[cat_idx];
			tot_rv_s1 <= tot_vld_q[cat_idx];
		end
		if (cmd.tot_wr && cat_ok) begin
			tot_mem[cat_idx] <= {new_tp, new_fp, new_fn};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_vld_q <= '0;
		end else if (cmd.tot_wr && cat_ok) begin
			tot_vld_q[cat_idx] <= 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.decide || cmd.tot_wr) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			o_kind    <= KIND_VERDICT;
			o_matched <= hit;
			o_slot    <= hit ? SLOT_OUT_W'(best_q) : '0;
			o_cat     <= '0;
			o_tp      <= '0;
			o_fp      <= '0;
			o_fn      <= '0;
			o_ovf     <= ovf_q;
		end else if (cmd.tot_wr) begin
			o_kind    <= KIND_TOTALS;
			o_matched <= 1'b0;
			o_slot    <= '0;
			o_cat     <= cat_q;
			o_tp      <= cat_ok ? new_tp : '0;
			o_fp      <= cat_ok ? new_fp : '0;
			o_fn      <= cat_ok ? new_fn : '0;
			o_ovf     <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;

	// Status to the controller
	always_comb begin
		sts.count_zero = (count_q == '0);
		sts.live       = rd_vld_s1;
		sts.last_slot  = ((CNT_W'(slot_q) + CNT_W'(1)) == count_q);
		sts.out_free   = !out_valid_q || out_ready;
	end

endmodule
`default_nettype wire

FILE: sim/greedy_iou_box_matcher_tb.sv
// Self-checking testbench for the greedy IoU box matcher.
`default_nettype none
module greedy_iou_box_matcher_tb;
	import gibm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NTRUTH = 32;
	localparam int NCAT = 64;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		op_t         op;
		logic [5:0]  cat;
		logic [12:0] x;
		logic [12:0] y;
		logic [12:0] w;
		logic [12:0] h;
	} box_op_t;

	typedef struct packed {
		logic        kind;
		logic        matched;
		logic [4:0]  slot;
		logic [5:0]  cat;
		logic [31:0] tp;
		logic [31:0] fp;
		logic [31:0] fn;
		logic        ovf;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [THR_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] operation = '0;
	logic [5:0] category = '0;
	logic [12:0] box_x = '0, box_y = '0, box_w = '0, box_h = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic kind, matched, store_overflow;
	logic [4:0] truth_slot;
	logic [5:0] out_category;
	logic [31:0] tp_total, fp_total, fn_total;

	greedy_iou_box_matcher u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .operation(operation),
		.category(category), .box_x(box_x), .box_y(box_y), .box_w(box_w),
		.box_h(box_h), .out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .matched(matched), .truth_slot(truth_slot),
		.out_category(out_category), .tp_total(tp_total), .fp_total(fp_total),
		.fn_total(fn_total), .store_overflow(store_overflow)
	);

	always #1 clk = ~clk;

	// Matcher state mirrored by the predictor
	logic [12:0] gt_x[NTRUTH], gt_y[NTRUTH], gt_w[NTRUTH], gt_h[NTRUTH];
	logic gt_live[NTRUTH];
	int unsigned gt_count, img_tp, img_dets;
	logic img_ovf;
	logic [31:0] cat_tp[NCAT], cat_fp[NCAT], cat_fn[NCAT];
	logic [16:0] thr;

	box_op_t pending_ops[$];
	verdict_t expected_verdicts[$];
	int unsigned errors = 0, n_verdicts = 0, n_totals = 0, n_hits = 0;
	int send_idle_pct = 0, recv_stall_pct = 0;
	int unsigned quiet_cycles = 0;

	// Append a transaction to the stimulus queue
	task automatic add_op(box_op_t t);
		pending_ops.insert(pending_ops.size(), t);
	endtask

	function automatic logic [31:0] sat_sum(logic [31:0] a, longint unsigned b);
		longint unsigned s;
		s = longint'(a) + b;
		return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// Overlap and union of a stored box against a detection
	task automatic box_overlap(int i, box_op_t d, output longint num, output longint den);
		longint sx, sy, inter, uni;
		sx = ((longint'(gt_x[i]) + gt_w[i] < longint'(d.x) + d.w) ?
			longint'(gt_x[i]) + gt_w[i] : longint'(d.x) + d.w) -
			((gt_x[i] > d.x) ? gt_x[i] : d.x) + 1;
		sy = ((longint'(gt_y[i]) + gt_h[i] < longint'(d.y) + d.h) ?
			longint'(gt_y[i]) + gt_h[i] : longint'(d.y) + d.h) -
			((gt_y[i] > d.y) ? gt_y[i] : d.y) + 1;
		if (sx < 0) sx = 0;
		if (sy < 0) sy = 0;
		inter = sx * sy;
		uni = longint'(gt_w[i]) * gt_h[i] + longint'(d.w) * d.h - inter;
		if (uni <= 0) begin
			num = 0;
			den = 1;
		end else begin
			num = inter;
			den = uni;
		end
	endtask

	// Advance the mirrored state and queue the expected result
	task automatic predict_match(box_op_t t);
		verdict_t v;
		longint n, d, bn, bd;
		int best;
		bit found;
		v = '0;
		case (t.op)
			OP_START: begin
				foreach (gt_live[i]) gt_live[i] = 1'b0;
				gt_count = 0;
				img_tp = 0;
				img_dets = 0;
				img_ovf = 1'b0;
			end
			OP_LOAD: begin
				if (gt_count < NTRUTH) begin
					gt_x[gt_count] = t.x;
					gt_y[gt_count] = t.y;
					gt_w[gt_count] = t.w;
					gt_h[gt_count] = t.h;
					gt_live[gt_count] = 1'b1;
					gt_count++;
				end else begin
					img_ovf = 1'b1;
				end
			end
			OP_DETECT: begin
				found = 0;
				best = 0;
				bn = 0;
				bd = 1;
				for (int i = 0; i < NTRUTH; i++) begin
					if (gt_live[i]) begin
						if (!found) begin
							found = 1;
							best = i;
						end
						box_overlap(i, t, n, d);
						if (n * bd > bn * d) begin
							best = i;
							bn = n;
							bd = d;
						end
					end
				end
				if (found && bn * 65536 >= longint'(thr) * bd) begin
					v.matched = 1'b1;
					v.slot = best[4:0];
					gt_live[best] = 1'b0;
					if (img_tp < 16'hFFFF) img_tp++;
				end
				if (img_dets < 16'hFFFF) img_dets++;
				v.kind = KIND_VERDICT;
				v.ovf = img_ovf;
				expected_verdicts.insert(expected_verdicts.size(), v);
			end
			default: begin
				int unsigned left;
				left = 0;
				foreach (gt_live[i]) if (gt_live[i]) left++;
				cat_tp[t.cat] = sat_sum(cat_tp[t.cat], img_tp);
				cat_fp[t.cat] = sat_sum(cat_fp[t.cat], img_dets - img_tp);
				cat_fn[t.cat] = sat_sum(cat_fn[t.cat], left);
				v.kind = KIND_TOTALS;
				v.cat = t.cat;
				v.tp = cat_tp[t.cat];
				v.fp = cat_fp[t.cat];
				v.fn = cat_fn[t.cat];
				v.ovf = img_ovf;
				expected_verdicts.insert(expected_verdicts.size(), v);
			end
		endcase
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// Driver: present queued transactions, with random sender gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_match(box_op_t'({operation, category, box_x, box_y, box_w, box_h}));
			end
			if (!in_valid || in_ready) begin
				if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					box_op_t t;
					t = pending_ops.pop_front();
					in_valid <= 1'b1;
					operation <= t.op;
					category <= t.cat;
					box_x <= t.x;
					box_y <= t.y;
					box_w <= t.w;
					box_h <= t.h;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transaction, stall the receiver at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				verdict_t e;
				if (expected_verdicts.size() == 0) begin
					report_mismatch("unexpected result", kind, 0);
				end else begin
					e = expected_verdicts.pop_front();
					if (kind !== e.kind) report_mismatch("kind", kind, e.kind);
					if (matched !== e.matched) report_mismatch("matched", matched, e.matched);
					if (truth_slot !== e.slot) report_mismatch("truth_slot", truth_slot, e.slot);
					if (out_category !== e.cat)
						report_mismatch("out_category", out_category, e.cat);
					if (tp_total !== e.tp) report_mismatch("tp_total", tp_total, e.tp);
					if (fp_total !== e.fp) report_mismatch("fp_total", fp_total, e.fp);
					if (fn_total !== e.fn) report_mismatch("fn_total", fn_total, e.fn);
					if (store_overflow !== e.ovf)
						report_mismatch("store_overflow", store_overflow, e.ovf);
					if (e.kind == KIND_TOTALS) n_totals++;
					else n_verdicts++;
					if (e.matched) n_hits++;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: end the run when nothing is accepted for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n ||
				(!in_valid && pending_ops.size() == 0 && expected_verdicts.size() == 0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog timeout");
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic box_op_t make_op(op_t op, logic [5:0] cat, logic [12:0] x,
			logic [12:0] y, logic [12:0] w, logic [12:0] h);
		return {op, cat, x, y, w, h};
	endfunction

	// Random box, mostly small, sometimes at full range
	function automatic box_op_t rand_box(op_t op);
		logic [12:0] x, y, w, h;
		if ($urandom_range(9) == 0) begin
			x = 13'($urandom);
			y = 13'($urandom);
			w = 13'($urandom);
			h = 13'($urandom);
		end else begin
			x = 13'($urandom_range(200));
			y = 13'($urandom_range(200));
			w = 13'($urandom_range(60));
			h = 13'($urandom_range(60));
		end
		return make_op(op, 6'($urandom), x, y, w, h);
	endfunction

	// Wait for all results, then let the block settle before a register write
	task automatic drain();
		while (pending_ops.size() > 0 || in_valid || expected_verdicts.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_threshold(logic [16:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		thr = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One image, with detections mostly jittered near its truth boxes
	task automatic queue_image();
		box_op_t gts[$], t;
		int ngt, ndet;
		ngt = ($urandom_range(19) == 0) ? 33 + $urandom_range(3) : $urandom_range(6);
		ndet = $urandom_range(6);
		add_op(make_op(OP_START, 6'($urandom), 13'($urandom), 13'($urandom),
			13'($urandom), 13'($urandom)));
		for (int i = 0; i < ngt; i++) begin
			t = rand_box(OP_LOAD);
			gts.insert(gts.size(), t);
			add_op(t);
		end
		for (int i = 0; i < ndet; i++) begin
			if (ngt > 0 && $urandom_range(3) != 0) begin
				t = gts[$urandom_range(ngt - 1)];
				t.op = OP_DETECT;
				t.x = t.x + 13'($urandom_range(4));
				t.y = t.y + 13'($urandom_range(4));
				t.w = t.w + 13'($urandom_range(4));
				t.h = t.h + 13'($urandom_range(4));
			end else begin
				t = rand_box(OP_DETECT);
			end
			add_op(t);
		end
		if ($urandom_range(9) == 0) add_op(rand_box(op_t'(2'($urandom))));
		add_op(rand_box(OP_END));
		if ($urandom_range(19) == 0) add_op(rand_box(OP_END));
	endtask

	initial begin
		int target;
		thr = THR_RESET;
		gt_count = 0;
		img_tp = 0;
		img_dets = 0;
		img_ovf = 1'b0;
		foreach (gt_live[i]) gt_live[i] = 1'b0;
		foreach (cat_tp[i]) begin
			cat_tp[i] = '0;
			cat_fp[i] = '0;
			cat_fn[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: detection and end before any start, extremes, identical boxes
		add_op(make_op(OP_DETECT, 0, 0, 0, 0, 0));
		add_op(make_op(OP_END, 63, 0, 0, 0, 0));
		add_op(make_op(OP_START, 0, 0, 0, 0, 0));
		add_op(make_op(OP_LOAD, 0, 8191, 8191, 8191, 8191));
		add_op(make_op(OP_LOAD, 0, 10, 10, 20, 20));
		add_op(make_op(OP_LOAD, 0, 0, 0, 0, 0));
		add_op(make_op(OP_DETECT, 0, 10, 10, 20, 20));
		add_op(make_op(OP_DETECT, 0, 8191, 8191, 8191, 8191));
		add_op(make_op(OP_DETECT, 0, 4000, 100, 5, 5));
		add_op(make_op(OP_DETECT, 0, 0, 0, 0, 0));
		add_op(make_op(OP_END, 5, 0, 0, 0, 0));
		add_op(make_op(OP_END, 5, 0, 0, 0, 0));
		add_op(make_op(OP_START, 0, 0, 0, 0, 0));
		add_op(make_op(OP_DETECT, 0, 1, 1, 1, 1));
		add_op(make_op(OP_END, 42, 8191, 0, 8191, 0));
		drain();

		// Threshold zero: a disjoint box still matches
		write_threshold(17'd0);
		add_op(make_op(OP_START, 0, 0, 0, 0, 0));
		add_op(make_op(OP_LOAD, 0, 0, 0, 3, 3));
		add_op(make_op(OP_DETECT, 0, 5000, 5000, 3, 3));
		add_op(make_op(OP_END, 1, 0, 0, 0, 0));
		drain();
		write_threshold(17'd65536);

		// Random images across idle phases and threshold settings
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 56; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 56; end
				default: begin send_idle_pct = 32; recv_stall_pct = 32; end
			endcase
			target = 250;
			while (target > 0) begin
				int before_n;
				before_n = pending_ops.size();
				queue_image();
				target -= pending_ops.size() - before_n;
			end
			drain();
			case (phase)
				0: write_threshold(17'd65535);
				1: write_threshold(17'd1);
				2: write_threshold(17'd32768);
				3: write_threshold(17'd39322);
				default: write_threshold(17'($urandom_range(65536)));
			endcase
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		repeat (300) @(posedge clk);

		$display("Checked %0d detection verdicts (%0d matched) and %0d category totals",
			n_verdicts, n_hits, n_totals);
		if (errors == 0 && expected_verdicts.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, expected_verdicts.size());
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
`default_nettype wire
